>>> rtl/svm_pkg.sv
// Shared types and constants for the stack machine execute unit.
package svm_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OPCODE_W = 5;
    localparam int unsigned OUTPC_W  = 16;
    localparam int unsigned PLEN_W   = 16;
    localparam int unsigned CCNT_W   = 9;
    localparam int unsigned ERR_W    = 4;
    localparam int unsigned CIDX_W   = 2;
    localparam int unsigned CDATA_W  = 16;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 5'd0,
        OP_SUB    = 5'd1,
        OP_MUL    = 5'd2,
        OP_DIV    = 5'd3,
        OP_EQ     = 5'd4,
        OP_GT     = 5'd5,
        OP_LT     = 5'd6,
        OP_JMP    = 5'd7,
        OP_JZ     = 5'd8,
        OP_STORE  = 5'd9,
        OP_LOAD   = 5'd10,
        OP_PUSHC  = 5'd11,
        OP_DROP   = 5'd12,
        OP_OUT    = 5'd13,
        OP_HALT   = 5'd14,
        OP_ENTER  = 5'd15,
        OP_LEAVE  = 5'd16,
        OP_CONSTW = 5'd17
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 4'd0,
        ERR_OVERFLOW  = 4'd1,
        ERR_UNDERFLOW = 4'd2,
        ERR_DIV_ZERO  = 4'd3,
        ERR_BAD_CONST = 4'd4,
        ERR_BAD_CMD   = 4'd5,
        ERR_BAD_OUT   = 4'd6,
        ERR_NESTED    = 4'd7,
        ERR_STRAY     = 4'd8,
        ERR_BAD_OP    = 4'd9,
        ERR_BAD_VAR   = 4'd10
    } err_t;

    typedef enum logic [1:0] {
        CFG_PROGRAM_LENGTH = 2'd0,
        CFG_CONSTANT_COUNT = 2'd1,
        CFG_COMMAND_COUNT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [OUTPC_W-1:0] next_pc;
        logic               print_valid;
        logic [WORD_W-1:0]  print_value;
        logic               exec_valid;
        logic [7:0]         exec_index;
        logic [ERR_W-1:0]   error_code;
        logic               halted;
    } result_t;

endpackage

>>> rtl/stack_vm_execute_unit_core.sv
// Top level of the stack machine execute unit: sequencer, memories and divider.
//
//  channel   | dir | handshake              | word
//  ----------+-----+------------------------+------------------------------------
//  s_        | in  | s_tvalid / s_tready    | one instruction or constant-pool load
//  m_        | out | m_tvalid / m_tready    | one result per instruction word
//  cfg_      | in  | cfg_valid / cfg_ready  | register index and write data
//
// The accept cycle issues the stack, variable and constant reads; the next cycle
// executes and writes back once the output register is free. mul adds a commit
// state for the registered product, div adds the ST_DIV state of the bit-serial
// divider ahead of its commit state. enter sweeps the sandbox variable bank with
// s_tready low. After reset the variable memory is swept once before the first
// word is taken. A stalled m_ side holds a finished result in the output
// register; the next instruction is accepted meanwhile and waits in execute
// until the register frees.
module stack_vm_execute_unit_core
    import svm_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 1024,
    parameter int unsigned VAR_COUNT   = 1024,
    parameter int unsigned CONST_DEPTH = 256,
    parameter int unsigned PC_WIDTH    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // opcode[4:0], operand[36:5], const_value[68:37], zero fill [71:69]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // next_pc[15:0], print_valid[16], print_value[48:17], exec_valid[49],
    // exec_index[57:50], error_code[61:58], halted[62], zero fill [63]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data
);

    localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SA_W = $clog2(2 * STACK_DEPTH);
    localparam int unsigned VI_W = $clog2(VAR_COUNT);
    localparam int unsigned VA_W = $clog2(2 * VAR_COUNT);
    localparam int unsigned CA_W = $clog2(CONST_DEPTH);
    localparam logic [SA_W-1:0] STK_BANK1 = SA_W'(STACK_DEPTH);
    localparam logic [VA_W-1:0] VAR_BANK1 = VA_W'(VAR_COUNT);
    localparam logic [VA_W-1:0] VAR_LAST  = VA_W'(2 * VAR_COUNT - 1);
    localparam logic [SP_W-1:0] SP_FULL   = SP_W'(STACK_DEPTH);

    // configuration
    logic [PLEN_W-1:0] plen_reg;
    logic [CCNT_W-1:0] ccnt_reg;
    logic [CCNT_W-1:0] cmdcnt_reg;

    // architectural state
    logic [PC_WIDTH-1:0] pc_reg;
    logic [SP_W-1:0]     sp0_reg, sp1_reg;
    logic                insb_reg;
    logic                halt_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [VA_W-1:0]   clr_reg;
    opcode_t           op_reg;
    logic [WORD_W-1:0] opd_reg, cv_reg;

    // memories
    logic [WORD_W-1:0] stack_mem [2*STACK_DEPTH];
    logic [WORD_W-1:0] var_mem   [2*VAR_COUNT];
    logic [WORD_W-1:0] const_mem [CONST_DEPTH];
    logic [WORD_W-1:0] rd_a_reg, rd_b_reg, rd_var_reg, rd_cst_reg;

    // arithmetic
    logic [WORD_W-1:0] mul_reg;
    logic [WORD_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic              neg_reg;
    logic [4:0]        cnt_reg;

    // output register
    logic    m_valid_reg;
    result_t m_res_reg;

    logic s_accept, out_free, commit;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    // pack the result fields from the lowest bit up
    assign m_tdata   = {1'b0, m_res_reg.halted, m_res_reg.error_code, m_res_reg.exec_index,
                        m_res_reg.exec_valid, m_res_reg.print_value, m_res_reg.print_valid,
                        m_res_reg.next_pc};

    // ---------------- read addresses, issued in the accept cycle ----------
    logic [SP_W-1:0]   sp_cur;
    logic [SA_W-1:0]   stk_base, stk_top, stk_second, stk_push;
    logic [VA_W-1:0]   var_addr;
    logic [CA_W-1:0]   cst_addr_in;
    logic [WORD_W-1:0] s_opd;

    assign sp_cur      = insb_reg ? sp1_reg : sp0_reg;
    assign stk_base    = insb_reg ? STK_BANK1 : '0;
    assign stk_top     = stk_base + SA_W'(sp_cur) - SA_W'(1);
    assign stk_second  = stk_base + SA_W'(sp_cur) - SA_W'(2);
    assign stk_push    = stk_base + SA_W'(sp_cur);
    assign s_opd       = s_tdata[36:5];
    assign cst_addr_in = s_opd[CA_W-1:0];

    // variable address: from the incoming word at accept, from the held one at commit
    logic [VI_W-1:0] var_idx;
    assign var_idx  = s_accept ? s_opd[VI_W-1:0] : opd_reg[VI_W-1:0];
    assign var_addr = (insb_reg ? VAR_BANK1 : '0) + VA_W'(var_idx);

    // ---------------- execute ----------------------------------------------
    logic              halted_now, active;
    logic [WORD_W-1:0] top, second, alu, div_val;
    logic [31:0]       pc32;
    logic [PC_WIDTH-1:0] pc_inc, npc;
    err_t              err;
    logic              push_st, pop1, pop2, var_we_c, cst_we_c;
    logic              do_halt, do_enter, do_leave;
    logic              print_v, exec_v;
    logic [SA_W-1:0]   st_waddr;
    logic [WORD_W-1:0] st_wdata;
    logic              need_mul, need_div;
    logic              opd_var_ok, opd_cst_ok;

    assign top        = rd_a_reg;
    assign second     = rd_b_reg;
    assign pc32       = 32'(pc_reg);
    assign halted_now = halt_reg || (pc32 >= 32'(plen_reg));
    assign active     = !halted_now && (op_reg != OP_CONSTW);
    assign pc_inc     = pc_reg + PC_WIDTH'(1);
    assign opd_var_ok = opd_reg < 32'(VAR_COUNT);
    assign opd_cst_ok = (opd_reg < 32'(ccnt_reg)) && (opd_reg < 32'(CONST_DEPTH));
    assign div_val    = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_comb begin
        unique case (op_reg)
            OP_ADD:  alu = second + top;
            OP_SUB:  alu = second - top;
            OP_MUL:  alu = mul_reg;
            OP_DIV:  alu = div_val;
            OP_EQ:   alu = WORD_W'(second == top);
            OP_GT:   alu = WORD_W'($signed(second) > $signed(top));
            OP_LT:   alu = WORD_W'($signed(second) < $signed(top));
            default: alu = '0;
        endcase
    end

    always_comb begin
        err      = ERR_NONE;
        npc      = pc_inc;
        push_st  = 1'b0;
        pop1     = 1'b0;
        pop2     = 1'b0;
        var_we_c = 1'b0;
        do_halt  = 1'b0;
        do_enter = 1'b0;
        do_leave = 1'b0;
        print_v  = 1'b0;
        exec_v   = 1'b0;
        st_waddr = stk_second;
        st_wdata = alu;
        cst_we_c = (op_reg == OP_CONSTW) && (opd_reg < 32'(CONST_DEPTH));
        if (active) begin
            unique case (op_reg)
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_LT: begin
                    priority if (sp_cur < SP_W'(2)) err = ERR_UNDERFLOW;
                    else if (op_reg == OP_DIV && top == '0) err = ERR_DIV_ZERO;
                    else pop2 = 1'b1;
                end
                OP_JMP: npc = opd_reg[PC_WIDTH-1:0];
                OP_JZ: begin
                    if (sp_cur == '0) err = ERR_UNDERFLOW;
                    else begin
                        pop1 = 1'b1;
                        if (top == '0) npc = opd_reg[PC_WIDTH-1:0];
                    end
                end
                OP_STORE: begin
                    priority if (sp_cur == '0) err = ERR_UNDERFLOW;
                    else if (!opd_var_ok) err = ERR_BAD_VAR;
                    else begin
                        pop1     = 1'b1;
                        var_we_c = 1'b1;
                    end
                end
                OP_LOAD: begin
                    priority if (!opd_var_ok) err = ERR_BAD_VAR;
                    else if (sp_cur >= SP_FULL) err = ERR_OVERFLOW;
                    else begin
                        push_st  = 1'b1;
                        st_waddr = stk_push;
                        st_wdata = rd_var_reg;
                    end
                end
                OP_PUSHC: begin
                    priority if (!opd_cst_ok) err = ERR_BAD_CONST;
                    else if (sp_cur >= SP_FULL) err = ERR_OVERFLOW;
                    else begin
                        push_st  = 1'b1;
                        st_waddr = stk_push;
                        st_wdata = rd_cst_reg;
                    end
                end
                OP_DROP: begin
                    if (sp_cur == '0) err = ERR_UNDERFLOW;
                    else pop1 = 1'b1;
                end
                OP_OUT: begin
                    priority if (opd_reg > 32'd1) err = ERR_BAD_OUT;
                    else if (sp_cur == '0) err = ERR_UNDERFLOW;
                    else if (opd_reg == 32'd0) begin
                        pop1    = 1'b1;
                        print_v = 1'b1;
                    end else if (top >= 32'(cmdcnt_reg) || top > 32'd255) begin
                        err = ERR_BAD_CMD;
                    end else begin
                        pop1   = 1'b1;
                        exec_v = 1'b1;
                    end
                end
                OP_HALT: do_halt = 1'b1;
                OP_ENTER: begin
                    if (insb_reg) err = ERR_NESTED;
                    else do_enter = 1'b1;
                end
                OP_LEAVE: begin
                    priority if (!insb_reg) err = ERR_STRAY;
                    else if (sp0_reg >= SP_FULL) err = ERR_OVERFLOW;
                    else begin
                        do_leave = 1'b1;
                        st_waddr = SA_W'(sp0_reg);
                        st_wdata = (sp1_reg == '0) ? '0 : top;
                    end
                end
                default: err = ERR_BAD_OP;
            endcase
        end
    end

    // binary ops write back the result in place of the second word
    logic st_we;
    assign need_mul = (state_reg == ST_EXEC) && active && op_reg == OP_MUL && err == ERR_NONE;
    assign need_div = (state_reg == ST_EXEC) && active && op_reg == OP_DIV && err == ERR_NONE;
    assign commit   = out_free && (((state_reg == ST_EXEC) && !need_mul && !need_div)
                                   || (state_reg == ST_COMMIT));
    assign st_we    = commit && (pop2 || push_st || do_leave);

    // ---------------- next state -------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == VAR_LAST) state_next = ST_IDLE;
            ST_IDLE:   if (s_accept) state_next = ST_EXEC;
            ST_EXEC: begin
                priority if (need_mul) state_next = ST_COMMIT;
                else if (need_div) state_next = ST_DIV;
                else if (out_free) state_next = do_enter ? ST_CLEAR : ST_IDLE;
            end
            ST_DIV:    if (cnt_reg == '0) state_next = ST_COMMIT;
            ST_COMMIT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer -----------------------------
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
    end

    // ---------------- control registers ------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            plen_reg    <= '0;
            ccnt_reg    <= '0;
            cmdcnt_reg  <= '0;
            pc_reg      <= '0;
            sp0_reg     <= '0;
            sp1_reg     <= '0;
            insb_reg    <= 1'b0;
            halt_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PROGRAM_LENGTH: plen_reg   <= cfg_data;
                    CFG_CONSTANT_COUNT: ccnt_reg   <= cfg_data[CCNT_W-1:0];
                    CFG_COMMAND_COUNT:  cmdcnt_reg <= cfg_data[CCNT_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + VA_W'(1);
            // hold the result until taken; a new one refills it
            if (commit) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (commit) begin
                if (active) begin
                    if (err != ERR_NONE) begin
                        halt_reg <= 1'b1;
                    end else begin
                        pc_reg <= npc;
                        if (do_halt) halt_reg <= 1'b1;
                        if (do_enter) begin
                            insb_reg <= 1'b1;
                            sp1_reg  <= '0;
                            clr_reg  <= VAR_BANK1;
                        end
                        if (do_leave) begin
                            insb_reg <= 1'b0;
                            sp1_reg  <= '0;
                            sp0_reg  <= sp0_reg + SP_W'(1);
                        end
                        if (pop1 || pop2 || push_st) begin
                            if (insb_reg)
                                sp1_reg <= push_st ? sp1_reg + SP_W'(1) : sp1_reg - SP_W'(1);
                            else
                                sp0_reg <= push_st ? sp0_reg + SP_W'(1) : sp0_reg - SP_W'(1);
                        end
                    end
                end
            end
        end
    end

    // ---------------- result word ------------------------------------------
    logic [PC_WIDTH-1:0] pc_after;
    logic                halt_after;
    logic                ok;
    assign ok         = active && err == ERR_NONE;
    assign pc_after   = ok ? npc : pc_reg;
    assign halt_after = halt_reg || (active && (err != ERR_NONE || do_halt));

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_res_reg.next_pc     <= OUTPC_W'(32'(pc_after));
            m_res_reg.print_valid <= ok && print_v;
            m_res_reg.print_value <= (ok && print_v) ? top : '0;
            m_res_reg.exec_valid  <= ok && exec_v;
            m_res_reg.exec_index  <= (ok && exec_v) ? top[7:0] : '0;
            m_res_reg.error_code  <= active ? err : ERR_NONE;
            m_res_reg.halted      <= halt_after || (32'(pc_after) >= 32'(plen_reg));
        end
    end

    // ---------------- held instruction word --------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= opcode_t'(s_tdata[4:0]);
            opd_reg <= s_opd;
            cv_reg  <= s_tdata[68:37];
        end
    end

    // ---------------- stack memory: two reads at accept, one write at commit
    always_ff @(posedge aclk) begin
        if (st_we) stack_mem[st_waddr] <= st_wdata;
        if (s_accept) begin
            rd_a_reg <= stack_mem[stk_top];
            rd_b_reg <= stack_mem[stk_second];
        end
    end

    // ---------------- variable memory: sweep, store, read at accept --------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) var_mem[clr_reg] <= '0;
        else if (commit && ok && var_we_c) var_mem[var_addr] <= top;
        if (s_accept) rd_var_reg <= var_mem[var_addr];
    end

    // ---------------- constant pool ----------------------------------------
    always_ff @(posedge aclk) begin
        if (commit && cst_we_c) const_mem[opd_reg[CA_W-1:0]] <= cv_reg;
        if (s_accept) rd_cst_reg <= const_mem[cst_addr_in];
    end

    // ---------------- multiplier and bit-serial divider --------------------
    logic [WORD_W:0]   div_sh, div_diff;
    logic              div_bit;
    assign div_sh   = {rem_reg, quo_reg[WORD_W-1]};
    assign div_diff = div_sh - {1'b0, dvs_reg};
    assign div_bit  = !div_diff[WORD_W];

    always_ff @(posedge aclk) begin
        if (need_mul) mul_reg <= second * top;
        if (need_div) begin
            rem_reg <= '0;
            quo_reg <= second[WORD_W-1] ? (32'd0 - second) : second;
            dvs_reg <= top[WORD_W-1] ? (32'd0 - top) : top;
            neg_reg <= second[WORD_W-1] ^ top[WORD_W-1];
            cnt_reg <= 5'd31;
        end else if (state_reg == ST_DIV) begin
            // restoring step: shift in the next dividend bit, subtract when it fits
            rem_reg <= div_bit ? div_diff[WORD_W-1:0] : div_sh[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], div_bit};
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

endmodule
